### rtl/core/srtu_pkg.sv
// ----------------------------------------------------------------------------
// srtu_pkg
// Shared types and constants of the sparse replacing trace update block.
// ----------------------------------------------------------------------------
package srtu_pkg;

    localparam int NUM_ACTIONS_DEF  = 32;
    localparam int NUM_FEATURES_DEF = 4096;

    localparam int OP_W     = 2;
    localparam int ACT_W    = 5;
    localparam int FEAT_W   = 12;
    localparam int TRACE_W  = 16;
    localparam int TOTAL_W  = 18;
    localparam int CFG_W    = 16;
    localparam int FACTOR_W = 2 * CFG_W;
    localparam int PROD_W   = TRACE_W + FACTOR_W;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [TRACE_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic [CFG_W-1:0] DISCOUNT_RST  = 16'd32440;
    localparam logic [CFG_W-1:0] DECAY_RST     = 16'd29491;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd328;

    localparam logic [1:0] REG_DISCOUNT    = 2'd0;
    localparam logic [1:0] REG_TRACE_DECAY = 2'd1;
    localparam logic [1:0] REG_PRUNE_THR   = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_DECAY = 2'd0,
        OP_MARK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        DC_NONE,
        DC_SWEEP,
        DC_LOAD,
        DC_RD_SLOT,
        DC_MARK,
        DC_ROW_START,
        DC_RD_LIST,
        DC_RD_TRACE,
        DC_MUL,
        DC_DECAY_WB,
        DC_CLR_WB,
        DC_ROW_END,
        DC_RD_FIN,
        DC_OUT
    } t_dcmd;

    typedef struct packed {
        logic sweep_done;
        logic row_done;
        logic row_last;
        t_op  op;
    } t_dstat;

endpackage

### rtl/core/srtu_item_if.sv
// ----------------------------------------------------------------------------
// srtu_item_if
// Input word channel: operation, action and feature index.
// ----------------------------------------------------------------------------
interface srtu_item_if;
    logic                        valid;
    logic                        ready;
    logic [srtu_pkg::OP_W-1:0]   op;
    logic [srtu_pkg::ACT_W-1:0]  action;
    logic [srtu_pkg::FEAT_W-1:0] feature_index;

    modport source (output valid, output op, output action, output feature_index,
                    input ready);
    modport sink   (input valid, input op, input action, input feature_index,
                    output ready);
endinterface

### rtl/core/srtu_result_if.sv
// ----------------------------------------------------------------------------
// srtu_result_if
// Result word channel: addressed trace and non-zero trace total.
// ----------------------------------------------------------------------------
interface srtu_result_if;
    logic                         valid;
    logic                         ready;
    logic [srtu_pkg::TRACE_W-1:0] trace_value;
    logic [srtu_pkg::TOTAL_W-1:0] nonzero_total;

    modport source (output valid, output trace_value, output nonzero_total,
                    input ready);
    modport sink   (input valid, input trace_value, input nonzero_total,
                    output ready);
endinterface

### rtl/core/srtu_datapath.sv
// ----------------------------------------------------------------------------
// srtu_datapath
// Trace, list and count memories, loop indices, decay arithmetic and the
// configuration registers, driven one command per cycle.
// ----------------------------------------------------------------------------
module srtu_datapath #(
    parameter int NUM_ACTIONS  = srtu_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_FEATURES = srtu_pkg::NUM_FEATURES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srtu_pkg::t_dcmd               i_cmd,
    output srtu_pkg::t_dstat              o_stat,
    input  logic [srtu_pkg::OP_W-1:0]     i_op,
    input  logic [srtu_pkg::ACT_W-1:0]    i_action,
    input  logic [srtu_pkg::FEAT_W-1:0]   i_feature_index,
    output logic [srtu_pkg::TRACE_W-1:0]  o_trace_value,
    output logic [srtu_pkg::TOTAL_W-1:0]  o_nonzero_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srtu_pkg::APB_AW-1:0]   paddr,
    input  logic [srtu_pkg::APB_DW-1:0]   pwdata,
    output logic [srtu_pkg::APB_DW-1:0]   prdata
);
    import srtu_pkg::*;

    localparam int DEPTH = NUM_ACTIONS * NUM_FEATURES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(NUM_FEATURES);
    localparam int CW    = $clog2(NUM_FEATURES + 1);
    localparam int AIW   = $clog2(NUM_ACTIONS);

    logic [TRACE_W-1:0] r_trace_mem [DEPTH];
    logic [FW-1:0]      r_list_mem  [DEPTH];
    logic [CW-1:0]      r_cnt_mem   [NUM_ACTIONS];

    logic [CFG_W-1:0]    r_disc, r_lambda, r_thr;
    t_op                 r_op;
    logic                r_ok;
    logic [AIW-1:0]      r_act;
    logic [FW-1:0]       r_feat;
    logic [AW-1:0]       r_slot, r_abase;
    logic [FACTOR_W-1:0] r_factor;
    logic [AIW-1:0]      r_a;
    logic [AW-1:0]       r_base, r_sw;
    logic [CW-1:0]       r_i, r_kept;
    logic [TOTAL_W-1:0]  r_total;
    logic [TRACE_W-1:0]  r_tr_q;
    logic [FW-1:0]       r_ls_q;
    logic [CW-1:0]       r_cnt_q;
    logic [PROD_W-1:0]   r_prod;
    logic [TRACE_W-1:0]  r_out_trace;
    logic [TOTAL_W-1:0]  r_out_total;

    logic                in_ok;
    logic                mark_add;
    logic [TOTAL_W-1:0]  v_full;
    logic [TRACE_W-1:0]  v_clamp;
    logic                keep;
    logic [AW-1:0]       elem_addr;
    logic                tr_re, tr_we, ls_we, cnt_re, cnt_we;
    logic [AW-1:0]       tr_ra, tr_wa, ls_wa;
    logic [TRACE_W-1:0]  tr_wd;
    logic [FW-1:0]       ls_wd;
    logic [AIW-1:0]      cnt_ra, cnt_wa;
    logic [CW-1:0]       cnt_wd;
    logic                cfg_we;

    assign in_ok = (32'(i_action) < NUM_ACTIONS) && (32'(i_feature_index) < NUM_FEATURES);
    assign mark_add = r_ok && (r_tr_q == '0) && (r_cnt_q < CW'(NUM_FEATURES));
    assign v_full = r_prod[PROD_W-1:30];
    assign v_clamp = (v_full > TOTAL_W'(ONE_Q15)) ? ONE_Q15 : v_full[TRACE_W-1:0];
    assign keep = (v_clamp != '0) && (v_clamp >= r_thr);
    assign elem_addr = r_base + AW'(r_ls_q);

    always_comb begin
        tr_re  = (i_cmd == DC_RD_SLOT) || (i_cmd == DC_RD_TRACE) || (i_cmd == DC_RD_FIN);
        tr_ra  = (i_cmd == DC_RD_TRACE) ? elem_addr : r_slot;
        cnt_re = (i_cmd == DC_RD_SLOT) || (i_cmd == DC_ROW_START);
        cnt_ra = (i_cmd == DC_RD_SLOT) ? r_act : r_a;
        tr_we  = 1'b0;
        tr_wa  = elem_addr;
        tr_wd  = '0;
        ls_we  = 1'b0;
        ls_wa  = r_base + AW'(r_kept);
        ls_wd  = r_ls_q;
        cnt_we = 1'b0;
        cnt_wa = r_a;
        cnt_wd = r_kept;
        case (i_cmd)
            DC_SWEEP: begin
                tr_we  = 1'b1;
                tr_wa  = r_sw;
                cnt_we = 32'(r_sw) < NUM_ACTIONS;
                cnt_wa = r_sw[AIW-1:0];
                cnt_wd = '0;
            end
            DC_MARK: begin
                tr_we  = r_ok;
                tr_wa  = r_slot;
                tr_wd  = ONE_Q15;
                ls_we  = mark_add;
                ls_wa  = r_abase + AW'(r_cnt_q);
                ls_wd  = r_feat;
                cnt_we = mark_add;
                cnt_wa = r_act;
                cnt_wd = r_cnt_q + 1'b1;
            end
            DC_DECAY_WB: begin
                tr_we = 1'b1;
                tr_wd = keep ? v_clamp : '0;
                ls_we = keep;
            end
            DC_CLR_WB: begin
                tr_we = 1'b1;
            end
            DC_ROW_END: begin
                cnt_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) r_trace_mem[tr_wa] <= tr_wd;
        if (tr_re) r_tr_q <= r_trace_mem[tr_ra];
        if (ls_we) r_list_mem[ls_wa] <= ls_wd;
        if (i_cmd == DC_RD_LIST) r_ls_q <= r_list_mem[r_base + AW'(r_i)];
        if (cnt_we) r_cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == DC_LOAD) begin
            r_act    <= AIW'(i_action);
            r_feat   <= FW'(i_feature_index);
            r_slot   <= AW'(32'(i_action) * NUM_FEATURES + 32'(i_feature_index));
            r_abase  <= AW'(32'(i_action) * NUM_FEATURES);
            r_factor <= r_disc * r_lambda;
        end
        if (i_cmd == DC_MUL) r_prod <= r_tr_q * r_factor;
        if (i_cmd == DC_OUT) begin
            r_out_trace <= r_ok ? r_tr_q : '0;
            r_out_total <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_READ;
            r_ok    <= 1'b0;
            r_a     <= '0;
            r_base  <= '0;
            r_sw    <= '0;
            r_i     <= '0;
            r_kept  <= '0;
            r_total <= '0;
        end else begin
            case (i_cmd)
                DC_SWEEP: r_sw <= r_sw + 1'b1;
                DC_LOAD: begin
                    r_op   <= t_op'(i_op);
                    r_ok   <= in_ok;
                    r_a    <= '0;
                    r_base <= '0;
                    if (t_op'(i_op) == OP_DECAY || t_op'(i_op) == OP_CLEAR) r_total <= '0;
                end
                DC_MARK: if (mark_add) r_total <= r_total + 1'b1;
                DC_ROW_START: begin
                    r_i    <= '0;
                    r_kept <= '0;
                end
                DC_DECAY_WB: begin
                    r_i <= r_i + 1'b1;
                    if (keep) r_kept <= r_kept + 1'b1;
                end
                DC_CLR_WB: r_i <= r_i + 1'b1;
                DC_ROW_END: begin
                    r_total <= r_total + TOTAL_W'(r_kept);
                    r_a     <= r_a + 1'b1;
                    r_base  <= r_base + AW'(NUM_FEATURES);
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc   <= DISCOUNT_RST;
            r_lambda <= DECAY_RST;
            r_thr    <= THRESHOLD_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_DISCOUNT:    r_disc   <= pwdata[CFG_W-1:0];
                REG_TRACE_DECAY: r_lambda <= pwdata[CFG_W-1:0];
                REG_PRUNE_THR:   r_thr    <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DISCOUNT:    prdata = APB_DW'(r_disc);
            REG_TRACE_DECAY: prdata = APB_DW'(r_lambda);
            REG_PRUNE_THR:   prdata = APB_DW'(r_thr);
            default:         prdata = '0;
        endcase
    end

    assign o_stat.sweep_done = (r_sw == AW'(DEPTH - 1));
    assign o_stat.row_done   = (r_i == r_cnt_q);
    assign o_stat.row_last   = (r_a == AIW'(NUM_ACTIONS - 1));
    assign o_stat.op         = r_op;
    assign o_trace_value     = r_out_trace;
    assign o_nonzero_total   = r_out_total;

endmodule

### rtl/core/srtu_ctrl.sv
// ----------------------------------------------------------------------------
// srtu_ctrl
// Sequencer: clearing sweep, mark, row walk for decay and clear, result word.
// ----------------------------------------------------------------------------
module srtu_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [srtu_pkg::OP_W-1:0] i_op,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  srtu_pkg::t_dstat          i_stat,
    output srtu_pkg::t_dcmd           o_cmd
);
    import srtu_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_SLOT_RD,
        S_MARK,
        S_ROW_START,
        S_ROW_CHK,
        S_RD_LIST,
        S_RD_TRACE,
        S_MUL,
        S_DECAY_WB,
        S_CLR_WB,
        S_ROW_END,
        S_RD_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = o_in_ready && i_in_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        case (r_state)
            S_SWEEP:     o_cmd = DC_SWEEP;
            S_IDLE:      o_cmd = accept ? DC_LOAD : DC_NONE;
            S_SLOT_RD:   o_cmd = DC_RD_SLOT;
            S_MARK:      o_cmd = DC_MARK;
            S_ROW_START: o_cmd = DC_ROW_START;
            S_RD_LIST:   o_cmd = DC_RD_LIST;
            S_RD_TRACE:  o_cmd = DC_RD_TRACE;
            S_MUL:       o_cmd = DC_MUL;
            S_DECAY_WB:  o_cmd = DC_DECAY_WB;
            S_CLR_WB:    o_cmd = DC_CLR_WB;
            S_ROW_END:   o_cmd = DC_ROW_END;
            S_RD_FIN:    o_cmd = DC_RD_FIN;
            S_OUT:       o_cmd = out_free ? DC_OUT : DC_NONE;
            default:     o_cmd = DC_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: if (i_stat.sweep_done) r_state <= S_IDLE;
                S_IDLE: begin
                    if (accept) begin
                        case (t_op'(i_op))
                            OP_MARK:  r_state <= S_SLOT_RD;
                            OP_DECAY: r_state <= S_ROW_START;
                            OP_CLEAR: r_state <= S_ROW_START;
                            default:  r_state <= S_RD_FIN;
                        endcase
                    end
                end
                S_SLOT_RD:   r_state <= S_MARK;
                S_MARK:      r_state <= S_RD_FIN;
                S_ROW_START: r_state <= S_ROW_CHK;
                S_ROW_CHK:   r_state <= i_stat.row_done ? S_ROW_END : S_RD_LIST;
                S_RD_LIST:   r_state <= (i_stat.op == OP_CLEAR) ? S_CLR_WB : S_RD_TRACE;
                S_RD_TRACE:  r_state <= S_MUL;
                S_MUL:       r_state <= S_DECAY_WB;
                S_DECAY_WB:  r_state <= S_ROW_CHK;
                S_CLR_WB:    r_state <= S_ROW_CHK;
                S_ROW_END:   r_state <= i_stat.row_last ? S_RD_FIN : S_ROW_START;
                S_RD_FIN:    r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/sparse_replacing_trace_update.sv
// ----------------------------------------------------------------------------
// sparse_replacing_trace_update
// Eligibility trace store with per-action lists of non-zero traces.
//
//   channel   dir  handshake        word
//   i_item    in   valid / ready    op, action, feature_index
//   o_result  out  valid / ready    trace_value, nonzero_total
//   apb       in   psel / penable   discount, trace_decay, prune_threshold
//
// Mark runs load, slot read, mark, final trace read and output, from the
// accepting cycle back to idle; read-back runs load, final read and output.
// Decay and clear walk every action row: per row a count read, per listed trace a
// list read and a write-back, for decay after a trace read and a multiply.
// After reset a sweep over all NUM_ACTIONS*NUM_FEATURES entries zeroes the traces.
// A waiting result word holds in the output register while the next word
// is taken; the block stalls only when a second result is ready first.
// ----------------------------------------------------------------------------
module sparse_replacing_trace_update #(
    parameter int NUM_ACTIONS  = srtu_pkg::NUM_ACTIONS_DEF,
    parameter int NUM_FEATURES = srtu_pkg::NUM_FEATURES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    srtu_item_if.sink                   i_item,
    srtu_result_if.source               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srtu_pkg::APB_AW-1:0] paddr,
    input  logic [srtu_pkg::APB_DW-1:0] pwdata,
    output logic [srtu_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import srtu_pkg::*;

    t_dcmd  cmd;
    t_dstat stat;

    assign pready = 1'b1;

    srtu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_op        (i_item.op),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    srtu_datapath #(
        .NUM_ACTIONS  (NUM_ACTIONS),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_item.op),
        .i_action        (i_item.action),
        .i_feature_index (i_item.feature_index),
        .o_trace_value   (o_result.trace_value),
        .o_nonzero_total (o_result.nonzero_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata)
    );

endmodule

### rtl/core/srtu_checker.sv
// ----------------------------------------------------------------------------
// srtu_checker
// Port-level checks of the trace store, bound to the top level.
// ----------------------------------------------------------------------------
module srtu_checker #(
    parameter int TOTAL_MAX = srtu_pkg::NUM_ACTIONS_DEF * srtu_pkg::NUM_FEATURES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [srtu_pkg::TRACE_W-1:0] i_trace_value,
    input logic [srtu_pkg::TOTAL_W-1:0] i_nonzero_total
);
    import srtu_pkg::*;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while an item is at work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_trace_value) && $stable(i_nonzero_total))
        else $error("stalled result word changed");

    a_trace_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_trace_value <= ONE_Q15)
        else $error("trace above one");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_nonzero_total) <= TOTAL_MAX)
        else $error("non-zero total above table size");

endmodule

bind sparse_replacing_trace_update srtu_checker #(
    .TOTAL_MAX (NUM_ACTIONS * NUM_FEATURES)
) u_srtu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_trace_value   (o_result.trace_value),
    .i_nonzero_total (o_result.nonzero_total)
);
